### design/eau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eau_pkg: shared types and constants for the effective address unit
// Word layouts, operation/mode/kind codes and register file sizing.
// ----------------------------------------------------------------------------
package eau_pkg;

  localparam int DATA_W   = 32;
  localparam int RF_DEPTH = 16;
  localparam int RF_AW    = 4;

  // Operation codes
  localparam logic [2:0] OP_READ  = 3'd0;
  localparam logic [2:0] OP_WRITE = 3'd1;
  localparam logic [2:0] OP_PEEK  = 3'd2;
  localparam logic [2:0] OP_CTRL  = 3'd3;
  localparam logic [2:0] OP_LDREG = 3'd4;
  localparam logic [2:0] OP_LDPC  = 3'd5;

  // Addressing modes
  localparam logic [3:0] MD_DREG   = 4'd0;
  localparam logic [3:0] MD_AREG   = 4'd1;
  localparam logic [3:0] MD_IND    = 4'd2;
  localparam logic [3:0] MD_POSTI  = 4'd3;
  localparam logic [3:0] MD_PRED   = 4'd4;
  localparam logic [3:0] MD_DISP   = 4'd5;
  localparam logic [3:0] MD_INDEX  = 4'd6;
  localparam logic [3:0] MD_ABSW   = 4'd7;
  localparam logic [3:0] MD_ABSL   = 4'd8;
  localparam logic [3:0] MD_PCDISP = 4'd9;
  localparam logic [3:0] MD_PCIDX  = 4'd10;
  localparam logic [3:0] MD_IMM    = 4'd11;

  // Operand sizes
  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_WORD = 2'd1;

  // Operand kinds
  localparam logic [1:0] KIND_REG  = 2'd0;
  localparam logic [1:0] KIND_MEM  = 2'd1;
  localparam logic [1:0] KIND_IMM  = 2'd2;
  localparam logic [1:0] KIND_NONE = 2'd3;

  // Stack pointer register index (A7)
  localparam logic [RF_AW-1:0] REG_SP = 4'd15;

  typedef struct packed {
    logic [2:0]  operation;
    logic [3:0]  mode;
    logic [3:0]  reg_number;
    logic [1:0]  size;
    logic [31:0] ext_words;
    logic [31:0] write_value;
  } in_word_t;

  typedef struct packed {
    logic [31:0] ea_address;
    logic [1:0]  operand_kind;
    logic [31:0] register_value;
    logic [31:0] immediate_value;
    logic [31:0] pc_after;
    logic [1:0]  words_used;
    logic        mode_error;
  } out_word_t;

  // Register file write request
  typedef struct packed {
    logic              en;
    logic [RF_AW-1:0]  addr;
    logic [DATA_W-1:0] data;
  } rf_wr_t;

endpackage

### design/effective_address_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// effective_address_unit: operand effective address resolution
// Input register, single-pass resolve, result register; owns the register
// file and the program counter.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry one operand request word (operation,
//   mode, register, size, extension words, write data). out_valid/
//   out_ready/out_data return one result word per request, in order.
//   A request is registered at acceptance, and its result word is
//   registered as it advances. Throughput is one word per cycle unless the
//   receiver stalls: the resolve logic is combinational between the input
//   and result registers, and the register file read is issued at
//   acceptance with a bypass for the write landing on that edge.
//   Register and PC updates take effect as the result is registered, so a
//   following request sees them.
//   When the receiver stalls, the result register holds and the input
//   register holds behind it; in_ready drops only when both are full.
//   Synchronous reset clears the register file, the PC and all valid flags.
// ----------------------------------------------------------------------------
module effective_address_unit
  import eau_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  logic              in_vld_r;
  in_word_t          in_r;
  logic              out_vld_r;
  out_word_t         out_r;
  logic [DATA_W-1:0] pc_r;
  logic [DATA_W-1:0] pc_nxt;
  logic              advance;
  logic              accept;
  logic [DATA_W-1:0] base;
  logic [DATA_W-1:0] idx_val;
  out_word_t         res;
  rf_wr_t            rf_wr;
  rf_wr_t            rf_wr_g;

  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;
  assign accept   = in_valid && in_ready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_r <= in_data;
    end
  end

  // Register file, read at acceptance: base register and index register
  eau_regfile u_regfile (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (rf_wr_g),
    .rd_en     (accept),
    .rd_addr_a (in_data.reg_number),
    .rd_addr_b (in_data.ext_words[31:28]),
    .rd_data_a (base),
    .rd_data_b (idx_val)
  );

  eau_resolve u_resolve (
    .item    (in_r),
    .base    (base),
    .idx_val (idx_val),
    .pc      (pc_r),
    .res     (res),
    .rf_wr   (rf_wr),
    .pc_nxt  (pc_nxt)
  );

  // Commit the state update only as the word moves to the result register
  always_comb begin
    rf_wr_g    = rf_wr;
    rf_wr_g.en = rf_wr.en && advance;
    if (in_r.operation == OP_LDREG) begin
      rf_wr_g.en   = advance;
      rf_wr_g.addr = in_r.reg_number;
      rf_wr_g.data = in_r.write_value;
    end
  end

  // Program counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0;
    end else if (advance) begin
      pc_r <= pc_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_pc_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(pc_r))
    else $error("pc changed without a word advancing");

  a_err_pc: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && res.mode_error) |=> (pc_r == $past(pc_r)))
    else $error("pc changed on a mode error");

  a_wr_gate: assert property (@(posedge clk) disable iff (!rst_n)
    rf_wr_g.en |-> advance)
    else $error("register file written while stalled");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (in_vld_r && out_vld_r && !out_ready))
    else $error("input stalled with room in the pipeline");

  a_out_fill: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_vld_r)
    else $error("advanced word lost from result register");
`endif

endmodule

### design/eau_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eau_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data (read-first).
// ----------------------------------------------------------------------------
module eau_ram
  import eau_pkg::*;
#(
  parameter int WIDTH = DATA_W,
  parameter int DEPTH = RF_DEPTH
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### design/eau_regfile.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eau_regfile: data/address register file with two registered read ports
// Reads are registered at issue; a write landing on the same edge is
// forwarded. Entries never written since reset read as zero.
// ----------------------------------------------------------------------------
module eau_regfile
  import eau_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  rf_wr_t            wr,
  input  logic              rd_en,
  input  logic [RF_AW-1:0]  rd_addr_a,
  input  logic [RF_AW-1:0]  rd_addr_b,
  output logic [DATA_W-1:0] rd_data_a,
  output logic [DATA_W-1:0] rd_data_b
);

  logic [RF_DEPTH-1:0] vld_r;
  logic                vld_a_r, vld_b_r;
  logic                hit_a_r, hit_b_r;
  logic [DATA_W-1:0]   byp_r;
  logic [DATA_W-1:0]   ram_a, ram_b;

  // Two copies, written together, one per read port
  eau_ram #(.WIDTH(DATA_W), .DEPTH(RF_DEPTH)) u_ram_a (
    .clk     (clk),
    .wr_en   (wr.en),
    .wr_addr (wr.addr),
    .wr_data (wr.data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr_a),
    .rd_data (ram_a)
  );

  eau_ram #(.WIDTH(DATA_W), .DEPTH(RF_DEPTH)) u_ram_b (
    .clk     (clk),
    .wr_en   (wr.en),
    .wr_addr (wr.addr),
    .wr_data (wr.data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr_b),
    .rd_data (ram_b)
  );

  // Track written entries; clear all at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.en) begin
      vld_r[wr.addr] <= 1'b1;
    end
  end

  // Capture entry valid and same-edge write hits alongside the read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
      hit_a_r <= 1'b0;
      hit_b_r <= 1'b0;
    end else if (rd_en) begin
      vld_a_r <= vld_r[rd_addr_a];
      vld_b_r <= vld_r[rd_addr_b];
      hit_a_r <= wr.en && (wr.addr == rd_addr_a);
      hit_b_r <= wr.en && (wr.addr == rd_addr_b);
    end
  end

  // Forwarded write data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      byp_r <= wr.data;
    end
  end

  assign rd_data_a = hit_a_r ? byp_r : (vld_a_r ? ram_a : '0);
  assign rd_data_b = hit_b_r ? byp_r : (vld_b_r ? ram_b : '0);

endmodule

### design/eau_resolve.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eau_resolve: single-pass operand resolution
// Decodes mode and operation, forms the address or value, and produces the
// register file write and next PC for one word.
// ----------------------------------------------------------------------------
module eau_resolve
  import eau_pkg::*;
(
  input  in_word_t          item,
  input  logic [DATA_W-1:0] base,
  input  logic [DATA_W-1:0] idx_val,
  input  logic [DATA_W-1:0] pc,
  output out_word_t         res,
  output rf_wr_t            rf_wr,
  output logic [DATA_W-1:0] pc_nxt
);

  function automatic logic [31:0] sext16(input logic [15:0] x);
    return {{16{x[15]}}, x};
  endfunction

  function automatic logic [31:0] sext8(input logic [7:0] x);
    return {{24{x[7]}}, x};
  endfunction

  logic [15:0] w0;
  logic [31:0] mask;
  logic [2:0]  adj;
  logic [31:0] idx_off;
  logic [31:0] new_reg;
  logic        allowed;
  logic        effects;
  logic [31:0] ea;
  logic [1:0]  kind;
  logic [31:0] rv;
  logic [31:0] iv;
  logic [1:0]  words;

  assign w0 = item.ext_words[31:16];

  // Size mask and address step (A7 stays word aligned for bytes)
  always_comb begin
    unique case (item.size)
      SZ_BYTE: begin
        mask = 32'h0000_00FF;
        adj  = (item.reg_number == REG_SP) ? 3'd2 : 3'd1;
      end
      SZ_WORD: begin
        mask = 32'h0000_FFFF;
        adj  = 3'd2;
      end
      default: begin
        mask = 32'hFFFF_FFFF;
        adj  = 3'd4;
      end
    endcase
  end

  // Index word: long or sign-extended word index plus 8-bit displacement
  assign idx_off = (w0[11] ? idx_val : sext16(idx_val[15:0])) + sext8(w0[7:0]);

  // Register-direct write value
  assign new_reg = (item.reg_number[3] && item.size == SZ_WORD) ?
                   sext16(item.write_value[15:0]) :
                   ((base & ~mask) | (item.write_value & mask));

  // Mode legality per operation
  always_comb begin
    priority if (item.operation == OP_READ || item.operation == OP_PEEK) begin
      allowed = (item.mode <= MD_IMM);
    end else if (item.operation == OP_WRITE) begin
      allowed = (item.mode <= MD_ABSL);
    end else begin
      allowed = (item.mode == MD_IND)    || (item.mode == MD_DISP)  ||
                (item.mode == MD_INDEX)  || (item.mode == MD_ABSW)  ||
                (item.mode == MD_ABSL)   || (item.mode == MD_PCDISP) ||
                (item.mode == MD_PCIDX);
    end
  end

  assign effects = (item.operation == OP_READ) || (item.operation == OP_WRITE);

  // Per-mode address, value and side effect
  always_comb begin
    ea         = '0;
    kind       = KIND_MEM;
    rv         = '0;
    iv         = '0;
    words      = 2'd0;
    rf_wr.en   = 1'b0;
    rf_wr.addr = item.reg_number;
    rf_wr.data = new_reg;
    unique case (item.mode)
      MD_DREG, MD_AREG: begin
        kind = KIND_REG;
        if (item.operation == OP_WRITE) begin
          rf_wr.en = 1'b1;
          rv       = new_reg & mask;
        end else begin
          rv = base & mask;
        end
      end
      MD_IND: begin
        ea = base;
      end
      MD_POSTI: begin
        ea         = base;
        rf_wr.en   = effects;
        rf_wr.data = base + {29'd0, adj};
      end
      MD_PRED: begin
        ea         = base - {29'd0, adj};
        rf_wr.en   = effects;
        rf_wr.data = base - {29'd0, adj};
      end
      MD_DISP: begin
        ea    = base + sext16(w0);
        words = 2'd1;
      end
      MD_INDEX: begin
        ea    = base + idx_off;
        words = 2'd1;
      end
      MD_ABSW: begin
        ea    = sext16(w0);
        words = 2'd1;
      end
      MD_ABSL: begin
        ea    = item.ext_words;
        words = 2'd2;
      end
      MD_PCDISP: begin
        ea    = pc + sext16(w0);
        words = 2'd1;
      end
      MD_PCIDX: begin
        ea    = pc + idx_off;
        words = 2'd1;
      end
      default: begin
        kind = KIND_IMM;
        if (item.size[1]) begin
          iv    = item.ext_words;
          words = 2'd2;
        end else begin
          iv    = (item.size == SZ_BYTE) ? {24'd0, w0[7:0]} : {16'd0, w0};
          words = 2'd1;
        end
      end
    endcase
  end

  // Select the final result and state update by operation
  always_comb begin
    res              = '0;
    res.operand_kind = KIND_NONE;
    res.pc_after     = pc;
    pc_nxt           = pc;
    if (item.operation == OP_LDPC) begin
      pc_nxt       = item.write_value;
      res.pc_after = item.write_value;
    end else if (item.operation > OP_LDPC || item.operation == OP_LDREG) begin
      res.mode_error = (item.operation > OP_LDPC);
    end else if (!allowed) begin
      res.mode_error = 1'b1;
    end else begin
      res.ea_address      = ea;
      res.operand_kind    = kind;
      res.register_value  = rv;
      res.immediate_value = iv;
      if (item.operation != OP_PEEK) begin
        pc_nxt         = pc + {29'd0, words, 1'b0};
        res.pc_after   = pc + {29'd0, words, 1'b0};
        res.words_used = words;
      end
    end
  end

endmodule
